/* hdl/gpme_pkg.sv */
// shared types, codes and fixed-point helpers for the grid moment engine
`timescale 1ns / 1ps
package gpme_pkg;

  // one grid point as it travels from the front to the back
  typedef struct packed {
    logic [31:0] position;
    logic [31:0] density;
    logic        last_point;
    logic        keep;
  } item_t;

  // arithmetic unit operation codes
  localparam logic [1:0] OP_MUL32 = 2'd0;
  localparam logic [1:0] OP_MUL33 = 2'd1;
  localparam logic [1:0] OP_DIV   = 2'd2;
  localparam logic [1:0] OP_SQRT  = 2'd3;

  // request to the arithmetic unit
  typedef struct packed {
    logic        start;
    logic [1:0]  code;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

  // moment kinds
  localparam logic [2:0] KIND_MEAN     = 3'd1;
  localparam logic [2:0] KIND_VARIANCE = 3'd2;
  localparam logic [2:0] KIND_SKEW     = 3'd3;
  localparam logic [2:0] KIND_KURT     = 3'd4;

  // area floor of 1e-9 in Q32.32, and 3.0 in Q32.32
  localparam logic [63:0] AREA_FLOOR = 64'd4;
  localparam logic [63:0] Q_THREE    = 64'h0000_0003_0000_0000;
  localparam logic [63:0] Q_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN      = 64'h8000_0000_0000_0000;

  // signed Q16.16 position to Q32.32
  function automatic logic [63:0] pos64(input logic [31:0] p);
    pos64 = {{16{p[31]}}, p, 16'h0000};
  endfunction

  // unsigned Q16.16 density to Q32.32
  function automatic logic [63:0] dens64(input logic [31:0] d);
    dens64 = {16'h0000, d, 16'h0000};
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? Q_MIN : Q_MAX;
    else sat_add = s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) sat_sub = s[64] ? Q_MIN : Q_MAX;
    else sat_sub = s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  // signed value from sign and magnitude, saturated
  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m,
                                           input logic over);
    if (neg) from_mag = (over || m[63]) ? Q_MIN : (64'd0 - m);
    else from_mag = (over || m[63]) ? Q_MAX : m;
  endfunction

endpackage

/* hdl/gpme_front.sv */
// front end: takes grid points and marks those that fit in the store
`timescale 1ns / 1ps
module gpme_front import gpme_pkg::*; #(
  parameter int GRID_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] position,
  input  logic [31:0] density,
  input  logic        last_point,
  input  logic        q_full,
  output logic        push,
  output item_t       item
);

  localparam int CW = $clog2(GRID_POINTS + 1);

  logic [CW-1:0] taken;

  // accept when the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // classify: points beyond the store size are dropped by the back end
  always_comb begin
    item.position   = position;
    item.density    = density;
    item.last_point = last_point;
    item.keep       = (taken < CW'(GRID_POINTS));
  end

  // count of points taken for the current distribution
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (push) begin
      if (last_point) taken <= '0;
      else if (item.keep) taken <= taken + CW'(1);
    end
  end

endmodule

/* hdl/gpme_queue.sv */
// two-entry queue between front and back
`timescale 1ns / 1ps
module gpme_queue import gpme_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item  = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

/* hdl/gpme_arith.sv */
// shared multi-cycle arithmetic: multiply, divide and square root in Q32.32
`timescale 1ns / 1ps
module gpme_arith import gpme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  arith_req_t  req,
  output logic        done,
  output logic [63:0] result
);

  logic         busy;
  logic [1:0]   code;
  logic [7:0]   cnt;
  logic         neg;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [63:0]  pp;
  logic [1:0]   pshift;
  logic [127:0] acc;
  logic [127:0] num;
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic         over;
  logic [47:0]  root;
  logic [50:0]  srem;

  logic [127:0] rnd;
  logic [64:0]  remsh;
  logic         dge;
  logic [63:0]  quo_next;
  logic         over_next;
  logic [50:0]  ssh;
  logic [50:0]  trial;
  logic         sge;
  logic [47:0]  root_next;

  // rounding of the product and one divide and root step
  always_comb begin
    rnd = acc + ((code == OP_MUL33) ? (128'd1 << 32) : (128'd1 << 31));
    remsh = {rem, num[127]};
    dge = (remsh >= {1'b0, mb});
    quo_next = {quo[62:0], dge};
    over_next = over || quo[63];
    ssh = {srem[48:0], num[127:126]};
    trial = {1'b0, root, 2'b01};
    sge = (ssh >= trial);
    root_next = {root[46:0], sge};
  end

  // sequencing of the active operation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        code <= req.code;
        cnt  <= '0;
        neg  <= req.a[63] != req.b[63];
        ma   <= mag(req.a);
        mb   <= mag(req.b);
        acc  <= '0;
        rem  <= '0;
        quo  <= '0;
        over <= 1'b0;
        root <= '0;
        srem <= '0;
        busy <= 1'b1;
        case (req.code)
          OP_DIV: begin
            num <= {32'd0, mag(req.a), 32'd0} + {64'd0, mag(req.b) >> 1};
            if (req.b == 64'd0) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= '0;
            end
          end
          OP_SQRT: begin
            num <= {req.a, 64'd0};
            if (req.a[63] || req.a == 64'd0) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= '0;
            end
          end
          default: begin
            num <= '0;
          end
        endcase
      end else if (busy) begin
        cnt <= cnt + 8'd1;
        case (code)
          OP_MUL32, OP_MUL33: begin
            // one 32x32 partial product per cycle, registered and then added to the accumulator
            if (cnt < 8'd4) begin
              pp     <= ma[{cnt[1], 5'b0} +: 32] * mb[{cnt[0], 5'b0} +: 32];
              pshift <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
            end
            if (cnt >= 8'd1 && cnt <= 8'd4) begin
              acc <= acc + ({64'd0, pp} << {pshift, 5'b0});
            end
            if (cnt == 8'd5) begin
              busy <= 1'b0;
              done <= 1'b1;
              if (code == OP_MUL33) result <= from_mag(neg, rnd[96:33], |rnd[127:97]);
              else result <= from_mag(neg, rnd[95:32], |rnd[127:96]);
            end
          end
          OP_DIV: begin
            // restoring division, one quotient bit per cycle
            num  <= {num[126:0], 1'b0};
            quo  <= quo_next;
            over <= over_next;
            rem  <= dge ? (remsh[63:0] - mb) : remsh[63:0];
            if (cnt == 8'd127) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= from_mag(neg, quo_next, over_next);
            end
          end
          default: begin
            // digit-by-digit root, two radicand bits per cycle
            num  <= {num[125:0], 2'b00};
            root <= root_next;
            srem <= sge ? (ssh - trial) : ssh;
            if (cnt == 8'd47) begin
              busy   <= 1'b0;
              done   <= 1'b1;
              result <= {16'd0, root_next};
            end
          end
        endcase
      end
    end
  end

endmodule

/* hdl/gpme_engine.sv */
// back end: grid store and trapezoidal passes for area and moments
`timescale 1ns / 1ps
module gpme_engine import gpme_pkg::*; #(
  parameter int GRID_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_data,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] moment_value,
  output logic        area_error
);

  localparam int AW = $clog2(GRID_POINTS);
  localparam int CW = $clog2(GRID_POINTS + 1);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_READ  = 4'd1;
  localparam logic [3:0] ST_FETCH = 4'd2;
  localparam logic [3:0] ST_TRAP  = 4'd3;
  localparam logic [3:0] ST_ADV   = 4'd4;
  localparam logic [3:0] ST_END   = 4'd5;
  localparam logic [3:0] ST_WAIT  = 4'd6;
  localparam logic [3:0] ST_DONE  = 4'd7;

  localparam logic [3:0] SP_F    = 4'd0;
  localparam logic [3:0] SP_D2   = 4'd1;
  localparam logic [3:0] SP_Z    = 4'd2;
  localparam logic [3:0] SP_T    = 4'd3;
  localparam logic [3:0] SP_TR   = 4'd4;
  localparam logic [3:0] SP_MEAN = 4'd5;
  localparam logic [3:0] SP_VAR  = 4'd6;
  localparam logic [3:0] SP_SQRT = 4'd7;
  localparam logic [3:0] SP_MOM  = 4'd8;

  logic [31:0]   pos_mem  [GRID_POINTS];
  logic [31:0]   dens_mem [GRID_POINTS];
  logic [31:0]   rd_pos;
  logic [31:0]   rd_dens;
  logic [CW-1:0] count;
  logic [AW-1:0] k;
  logic [3:0]    state;
  logic [3:0]    step;
  logic [1:0]    pass;
  logic [1:0]    erem;
  logic [2:0]    kind;
  logic [63:0]   acc;
  logic [63:0]   area;
  logic [63:0]   mean;
  logic [63:0]   sd;
  logic [63:0]   cur_p;
  logic [63:0]   cur_d;
  logic [63:0]   prev_p;
  logic [63:0]   prev_f;
  logic [63:0]   fval;
  logic [63:0]   zval;
  logic [63:0]   res_val;
  logic          res_err;
  arith_req_t    req;
  logic          ar_done;
  logic [63:0]   ar_res;
  logic          last_k;
  logic          kind_ok;

  gpme_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .done   (ar_done),
    .result (ar_res)
  );

  assign pop     = (state == ST_LOAD) && q_valid;
  assign last_k  = (CW'(k) + CW'(1) >= count);
  assign kind_ok = (kind == KIND_MEAN) || (kind == KIND_VARIANCE) ||
                   (kind == KIND_SKEW) || (kind == KIND_KURT);

  // grid store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (pop && q_item.keep) begin
      pos_mem[count[AW-1:0]]  <= q_item.position;
      dens_mem[count[AW-1:0]] <= q_item.density;
    end
    rd_pos  <= pos_mem[k];
    rd_dens <= dens_mem[k];
  end

  // moment kind register
  always_ff @(posedge clk) begin
    if (rst) kind <= KIND_MEAN;
    else if (cfg_write) kind <= cfg_data;
  end

  // pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      req.start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (q_valid) begin
            if (q_item.keep) count <= count + CW'(1);
            if (q_item.last_point) begin
              pass  <= 2'd0;
              k     <= '0;
              acc   <= '0;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          cur_p <= pos64(rd_pos);
          cur_d <= dens64(rd_dens);
          req.a <= pos64(rd_pos);
          case (pass)
            2'd0: begin
              fval  <= dens64(rd_dens);
              state <= ST_TRAP;
            end
            2'd1: begin
              req.start <= 1'b1;
              req.code  <= OP_MUL32;
              req.b     <= dens64(rd_dens);
              step      <= SP_F;
              state     <= ST_WAIT;
            end
            2'd2: begin
              req.start <= 1'b1;
              req.code  <= OP_MUL32;
              req.a     <= sat_sub(pos64(rd_pos), mean);
              req.b     <= sat_sub(pos64(rd_pos), mean);
              step      <= SP_D2;
              state     <= ST_WAIT;
            end
            default: begin
              req.start <= 1'b1;
              req.code  <= OP_DIV;
              req.a     <= sat_sub(pos64(rd_pos), mean);
              req.b     <= sd;
              step      <= SP_Z;
              state     <= ST_WAIT;
            end
          endcase
        end
        ST_TRAP: begin
          prev_p <= cur_p;
          prev_f <= fval;
          if (k == '0) begin
            state <= ST_ADV;
          end else begin
            req.start <= 1'b1;
            req.code  <= OP_MUL33;
            req.a     <= sat_sub(cur_p, prev_p);
            req.b     <= sat_add(prev_f, fval);
            step      <= SP_TR;
            state     <= ST_WAIT;
          end
        end
        ST_ADV: begin
          if (last_k) begin
            state <= ST_END;
          end else begin
            k     <= k + AW'(1);
            state <= ST_READ;
          end
        end
        ST_END: begin
          k     <= '0;
          req.a <= acc;
          req.b <= area;
          acc   <= '0;
          case (pass)
            2'd0: begin
              area <= acc;
              if ($signed(acc) <= $signed(AREA_FLOOR)) begin
                res_val <= '0;
                res_err <= 1'b1;
                state   <= ST_DONE;
              end else if (!kind_ok) begin
                res_val <= '0;
                res_err <= 1'b0;
                state   <= ST_DONE;
              end else begin
                pass  <= 2'd1;
                state <= ST_READ;
              end
            end
            2'd1: begin
              req.start <= 1'b1;
              req.code  <= OP_DIV;
              step      <= SP_MEAN;
              state     <= ST_WAIT;
            end
            2'd2: begin
              req.start <= 1'b1;
              req.code  <= OP_DIV;
              step      <= SP_VAR;
              state     <= ST_WAIT;
            end
            default: begin
              req.start <= 1'b1;
              req.code  <= OP_DIV;
              step      <= SP_MOM;
              state     <= ST_WAIT;
            end
          endcase
        end
        ST_WAIT: begin
          if (ar_done) begin
            res_err <= 1'b0;
            case (step)
              SP_F: begin
                fval  <= ar_res;
                state <= ST_TRAP;
              end
              SP_D2: begin
                req.start <= 1'b1;
                req.code  <= OP_MUL32;
                req.a     <= ar_res;
                req.b     <= cur_d;
                step      <= SP_F;
              end
              SP_Z: begin
                // power loop starts with t equal to z
                zval      <= ar_res;
                erem      <= kind[1:0] - 2'd2;
                req.start <= 1'b1;
                req.code  <= OP_MUL32;
                req.a     <= ar_res;
                req.b     <= ar_res;
                step      <= SP_T;
              end
              SP_T: begin
                req.start <= 1'b1;
                req.code  <= OP_MUL32;
                req.a     <= ar_res;
                if (erem != 2'd0) begin
                  erem  <= erem - 2'd1;
                  req.b <= zval;
                end else begin
                  req.b <= cur_d;
                  step  <= SP_F;
                end
              end
              SP_TR: begin
                acc   <= sat_add(acc, ar_res);
                state <= ST_ADV;
              end
              SP_MEAN: begin
                mean <= ar_res;
                if (kind == KIND_MEAN) begin
                  res_val <= ar_res;
                  state   <= ST_DONE;
                end else begin
                  pass  <= 2'd2;
                  state <= ST_READ;
                end
              end
              SP_VAR: begin
                if (kind == KIND_VARIANCE) begin
                  res_val <= ar_res;
                  state   <= ST_DONE;
                end else begin
                  req.start <= 1'b1;
                  req.code  <= OP_SQRT;
                  req.a     <= ar_res;
                  step      <= SP_SQRT;
                end
              end
              SP_SQRT: begin
                sd <= ar_res;
                if (ar_res == 64'd0) begin
                  res_val <= '0;
                  state   <= ST_DONE;
                end else begin
                  pass  <= 2'd3;
                  state <= ST_READ;
                end
              end
              default: begin
                res_val <= (kind == KIND_KURT) ? sat_sub(ar_res, Q_THREE) : ar_res;
                state   <= ST_DONE;
              end
            endcase
          end
        end
        ST_DONE: begin
          // hand the result to the output register once it is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            moment_value <= res_val;
            area_error   <= res_err;
            count        <= '0;
            state        <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(GRID_POINTS))
    else $error("grid point count beyond store size");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && area_error |-> moment_value == 64'd0)
    else $error("area error with nonzero moment");

  a_start_wait: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == ST_WAIT)
    else $error("arithmetic request outside wait state");

endmodule

/* hdl/grid_pdf_moment_engine_top.sv */
// top level of the grid density moment engine
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_stall) carries one grid point per request:
//   position (signed Q16.16), density (unsigned Q16.16) and last_point.
//   Points of one distribution arrive in order; last_point ends it.
//   Points beyond GRID_POINTS are dropped, a dropped last point still ends it.
//   Output channel (out_valid/out_stall) carries one request per distribution:
//   moment_value (signed Q32.32, saturated) and area_error.
//   cfg_write/cfg_data set moment_kind (1 mean, 2 variance, 3 skewness,
//   4 excess kurtosis); write only while idle. Reset value is 1.
//   Points load one per cycle through a two-entry queue while it has room.
//   After the last point the back end makes one trapezoidal pass over n
//   stored points per quantity, on one shared multiply/divide/root unit.
//   Each pass after the area pass ends in one divide by the area, and
//   skewness and kurtosis also take one root. Input stalls while the back
//   end works. A stalled output holds its result; the next distribution
//   can load meanwhile. Synchronous reset clears all control state.
module grid_pdf_moment_engine_top import gpme_pkg::*; #(
  parameter int GRID_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] position,
  input  logic [31:0] density,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] moment_value,
  output logic        area_error
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  gpme_front #(.GRID_POINTS(GRID_POINTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .position   (position),
    .density    (density),
    .last_point (last_point),
    .q_full     (q_full),
    .push       (push),
    .item       (push_item)
  );

  gpme_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  gpme_engine #(.GRID_POINTS(GRID_POINTS)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .moment_value (moment_value),
    .area_error   (area_error)
  );

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the grid density moment engine
`timescale 1ns / 1ps
module tb_top;
  import gpme_pkg::*;

  localparam int  NPTS        = 256;
  localparam int  CYCLE_LIMIT = 8000000;
  localparam logic [2:0] KIND_NONE0 = 3'd0;
  localparam logic [2:0] KIND_NONE5 = 3'd5;
  localparam logic [2:0] KIND_NONE6 = 3'd6;
  localparam logic [2:0] KIND_NONE7 = 3'd7;

  typedef logic signed [63:0] q_t;
  typedef struct {
    logic [31:0] pos;
    logic [31:0] dens;
    logic        last;
  } point_t;
  typedef struct {
    q_t   value;
    logic err;
  } moment_t;

  logic        clk, rst;
  logic        cfg_write;
  logic [2:0]  cfg_data;
  logic        in_valid, in_stall;
  logic [31:0] position, density;
  logic        last_point;
  logic        out_valid, out_stall;
  logic [63:0] moment_value;
  logic        area_error;

  point_t  point_queue[$];
  moment_t moment_queue[$];
  int      fail_count;
  int      cycle_count;
  int      items_made;
  logic    in_fire;

  // predictor copy of the block state
  logic [31:0] grid_pos[NPTS];
  logic [31:0] grid_dens[NPTS];
  int          grid_count;
  logic [2:0]  kind_now;
  q_t          work[NPTS];

  grid_pdf_moment_engine_top #(.GRID_POINTS(NPTS)) i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .position(position),
    .density(density), .last_point(last_point), .out_valid(out_valid),
    .out_stall(out_stall), .moment_value(moment_value), .area_error(area_error)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // saturating Q32.32 arithmetic
  function automatic q_t q_sat(input logic [64:0] s);
    if (s[64] != s[63]) q_sat = s[64] ? q_t'(64'h8000_0000_0000_0000)
                                      : q_t'(64'h7FFF_FFFF_FFFF_FFFF);
    else q_sat = q_t'(s[63:0]);
  endfunction

  function automatic q_t q_plus(input q_t a, input q_t b);
    q_plus = q_sat({a[63], a} + {b[63], b});
  endfunction

  function automatic q_t q_minus(input q_t a, input q_t b);
    q_minus = q_sat({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] q_abs(input q_t v);
    q_abs = v[63] ? 64'd0 - v : v;
  endfunction

  function automatic q_t q_signed(input logic neg, input logic [63:0] m, input logic over);
    if (neg) q_signed = (over || m[63]) ? q_t'(64'h8000_0000_0000_0000) : q_t'(64'd0 - m);
    else q_signed = (over || m[63]) ? q_t'(64'h7FFF_FFFF_FFFF_FFFF) : q_t'(m);
  endfunction

  // product scaled down by 2^sh, rounded half away from zero
  function automatic q_t q_mul(input q_t a, input q_t b, input int sh);
    logic [127:0] p;
    p = {64'd0, q_abs(a)} * {64'd0, q_abs(b)};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    q_mul = q_signed(a[63] != b[63], p[63:0], |p[127:64]);
  endfunction

  function automatic q_t q_div(input q_t a, input q_t b);
    logic [127:0] num, quo;
    logic [63:0]  ub;
    if (b == 0) return 0;
    ub  = q_abs(b);
    num = ({64'd0, q_abs(a)} << 32) + {64'd0, ub >> 1};
    quo = num / {64'd0, ub};
    q_div = q_signed(a[63] != b[63], quo[63:0], |quo[127:64]);
  endfunction

  // truncated root
  function automatic q_t q_root(input q_t v);
    logic [127:0] target;
    logic [63:0]  r, c;
    if (v <= 0) return 0;
    target = {64'd0, v} << 32;
    r = 0;
    for (int bitn = 47; bitn >= 0; bitn--) begin
      c = r | (64'd1 << bitn);
      if ({64'd0, c} * {64'd0, c} <= target) r = c;
    end
    q_root = q_t'(r);
  endfunction

  function automatic q_t x_at(input int k);
    x_at = q_t'({{16{grid_pos[k][31]}}, grid_pos[k], 16'h0000});
  endfunction

  function automatic q_t f_at(input int k);
    f_at = q_t'({16'h0000, grid_dens[k], 16'h0000});
  endfunction

  // trapezoidal rule over the work array
  function automatic q_t trapezoid_sum(input int n);
    q_t s;
    s = 0;
    for (int k = 0; k + 1 < n; k++)
      s = q_plus(s, q_mul(q_minus(x_at(k + 1), x_at(k)), q_plus(work[k], work[k + 1]), 33));
    trapezoid_sum = s;
  endfunction

  // moment of the stored grid under the current kind
  function automatic moment_t moment_of_grid(input int n);
    moment_t r;
    q_t area, mean, vari, sd, z, t;
    r.value = 0;
    r.err   = 1'b0;
    for (int k = 0; k < n; k++) work[k] = f_at(k);
    area = trapezoid_sum(n);
    if (area <= 4) begin
      r.err = 1'b1;
      return r;
    end
    if (!(kind_now inside {KIND_MEAN, KIND_VARIANCE, KIND_SKEW, KIND_KURT})) return r;
    for (int k = 0; k < n; k++) work[k] = q_mul(x_at(k), f_at(k), 32);
    mean = q_div(trapezoid_sum(n), area);
    if (kind_now == KIND_MEAN) begin
      r.value = mean;
      return r;
    end
    for (int k = 0; k < n; k++) begin
      z = q_minus(x_at(k), mean);
      work[k] = q_mul(q_mul(z, z, 32), f_at(k), 32);
    end
    vari = q_div(trapezoid_sum(n), area);
    if (kind_now == KIND_VARIANCE) begin
      r.value = vari;
      return r;
    end
    sd = q_root(vari);
    if (sd == 0) return r;
    for (int k = 0; k < n; k++) begin
      z = q_div(q_minus(x_at(k), mean), sd);
      t = z;
      for (int e = 1; e < kind_now; e++) t = q_mul(t, z, 32);
      work[k] = q_mul(t, f_at(k), 32);
    end
    r.value = q_div(trapezoid_sum(n), area);
    if (kind_now == KIND_KURT) r.value = q_minus(r.value, q_t'(Q_THREE));
    return r;
  endfunction

  // accepted point into the predictor
  task automatic take_point(input logic [31:0] p, input logic [31:0] d, input logic l);
    if (grid_count < NPTS) begin
      grid_pos[grid_count]  = p;
      grid_dens[grid_count] = d;
      grid_count++;
    end
    if (l) begin
      moment_queue.push_back(moment_of_grid(grid_count));
      grid_count = 0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // idle with a chance of 7 percent, with a quiet stretch each period
  function automatic logic idle_now();
    if ((cycle_count % 40000) < 8000) return 1'b0;
    return $urandom_range(99, 0) < 7;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (point_queue.size() != 0 && !idle_now()) begin
        position   <= point_queue[0].pos;
        density    <= point_queue[0].dens;
        last_point <= point_queue[0].last;
        in_valid   <= 1'b1;
        void'(point_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst ? 1'b0 : idle_now();
  end

  // monitor and checker
  always @(posedge clk) begin
    moment_t m;
    cycle_count <= cycle_count + 1;
    in_fire     <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) take_point(position, density, last_point);
    if (!rst && out_valid && !out_stall) begin
      if (moment_queue.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        m = moment_queue.pop_front();
        if (moment_value !== m.value)
          report_mismatch($sformatf("moment_value %h, expected %h", moment_value, m.value));
        if (area_error !== m.err)
          report_mismatch($sformatf("area_error %b, expected %b", area_error, m.err));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_point(input logic [31:0] p, input logic [31:0] d, input logic l);
    point_t pt;
    pt.pos  = p;
    pt.dens = d;
    pt.last = l;
    point_queue.push_back(pt);
    items_made++;
  endtask

  // one random distribution, mostly an ascending grid
  task automatic add_random_grid();
    int          n;
    logic [31:0] x, d;
    logic        noisy;
    n = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 2);
    noisy = $urandom_range(9, 0) == 0;
    x = $urandom_range(1, 0) ? $urandom : 32'($signed($urandom_range(200000, 0)) - 100000);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3, 0))
        0: d = $urandom;
        1: d = 32'd0;
        default: d = $urandom_range(32'h0010_0000, 0);
      endcase
      add_point(noisy ? $urandom : x, d, k == n - 1);
      x = x + $urandom_range(32'h0004_0000, 1);
    end
  endtask

  // wait for the block to drain, then set the kind
  task automatic set_kind(input logic [2:0] k);
    do @(negedge clk);
    while (point_queue.size() != 0 || in_valid || moment_queue.size() != 0);
    repeat (50) @(negedge clk);
    cfg_data  = k;
    cfg_write = 1'b1;
    kind_now  = k;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    logic [2:0] kinds[12];
    kinds = '{KIND_SKEW, KIND_MEAN, KIND_VARIANCE, KIND_SKEW, KIND_KURT, KIND_NONE0,
              KIND_NONE5, KIND_NONE6, KIND_NONE7, KIND_KURT, KIND_VARIANCE, KIND_MEAN};
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = KIND_MEAN;
    in_valid = 1'b0;
    out_stall = 1'b0;
    position = '0;
    density = '0;
    last_point = 1'b0;
    in_fire = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    items_made = 0;
    grid_count = 0;
    kind_now = KIND_MEAN;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, single point, zero width, descending, zero spread
    add_point(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    add_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_point(32'h0001_0000, 32'h0001_0000, 1'b1);
    add_point(32'h0002_0000, 32'h0001_0000, 1'b0);
    add_point(32'h0002_0000, 32'h0001_0000, 1'b1);
    add_point(32'h0005_0000, 32'h0001_0000, 1'b0);
    add_point(32'h0001_0000, 32'h0002_0000, 1'b1);
    add_point(32'h0003_0000, 32'h0004_0000, 1'b0);
    add_point(32'h0004_0000, 32'h0000_0000, 1'b1);
    add_point(32'hFFFF_0000, 32'h0000_0000, 1'b0);
    add_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    add_point(32'h0000_0000, 32'h0000_0001, 1'b0);
    add_point(32'h0000_0001, 32'h0000_0001, 1'b1);
    add_point(32'hFFFE_0000, 32'h0001_0000, 1'b0);
    add_point(32'h0000_0000, 32'h0003_0000, 1'b0);
    add_point(32'h0001_8000, 32'h0000_8000, 1'b0);
    add_point(32'h0004_0000, 32'h0000_0000, 1'b1);
    set_kind(KIND_MEAN);
    add_point(32'h0000_0000, 32'h0001_0000, 1'b0);
    add_point(32'h0001_0000, 32'h0001_0000, 1'b1);
    set_kind(KIND_KURT);
    add_point(32'hFFFE_0000, 32'h0001_0000, 1'b0);
    add_point(32'h0000_0000, 32'h0003_0000, 1'b0);
    add_point(32'h0002_0000, 32'h0001_0000, 1'b1);

    // full store: more points than fit, last one dropped
    for (int k = 0; k < NPTS + 4; k++)
      add_point(32'($signed(k - 128)) << 12, 32'h0000_4000 + 32'(k), k == NPTS + 3);

    // random phases over all kinds
    for (int ph = 0; ph < 12; ph++) begin
      set_kind(kinds[ph]);
      while (items_made < 300 + 140 * (ph + 1)) add_random_grid();
    end

    do @(negedge clk);
    while (point_queue.size() != 0 || in_valid || moment_queue.size() != 0);
    repeat (500) @(negedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
